### hdl/wtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtm_pkg
// shared types, codes and helpers for the watchpoint table matcher
// ----------------------------------------------------------------------------
package wtm_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam int ADDR_W   = 20;
  localparam int VALUE_W  = 16;
  localparam int METHOD_W = 3;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 4;
  localparam int BYTE_W   = 8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  // match methods
  localparam logic [METHOD_W-1:0] METH_UPDATE = 3'd0;
  localparam logic [METHOD_W-1:0] METH_EQ     = 3'd1;
  localparam logic [METHOD_W-1:0] METH_NE     = 3'd2;
  localparam logic [METHOD_W-1:0] METH_GT     = 3'd3;
  localparam logic [METHOD_W-1:0] METH_GE     = 3'd4;
  localparam logic [METHOD_W-1:0] METH_LT     = 3'd5;
  localparam logic [METHOD_W-1:0] METH_LE     = 3'd6;
  localparam logic [METHOD_W-1:0] METH_BAD    = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [VALUE_W-1:0]  value;
    logic [METHOD_W-1:0] method;
    logic                word;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted word and set up the walk
    logic walk;    // read the table at the pointer and advance
    logic commit;  // apply table update and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // pointer reached the end of the walk
    logic pend;       // a table read is still in flight
  } sts_t;

  function automatic logic method_fires(input logic [METHOD_W-1:0] method,
                                        input logic [VALUE_W-1:0]  data,
                                        input logic [VALUE_W-1:0]  ref_val);
    logic f;
    case (method)
      METH_UPDATE: f = 1'b1;
      METH_EQ:     f = (data == ref_val);
      METH_NE:     f = (data != ref_val);
      METH_GT:     f = (data >  ref_val);
      METH_GE:     f = (data >= ref_val);
      METH_LT:     f = (data <  ref_val);
      METH_LE:     f = (data <= ref_val);
      default:     f = 1'b0;
    endcase
    return f;
  endfunction

endpackage

### hdl/wtm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtm_ctrl
// sequencer: accept a word, walk the table, then hand out the result
// ----------------------------------------------------------------------------
module wtm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  wtm_pkg::sts_t sts,
  output wtm_pkg::cmd_t cmd
);
  import wtm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = !sts.walk_done;
        if (sts.walk_done && !sts.pend) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/wtm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtm_dpath
// entry memory, count, walk pointer, comparator and result register
// ----------------------------------------------------------------------------
module wtm_dpath #(
  parameter int ENTRIES = wtm_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wtm_pkg::cmd_t                 cmd,
  output wtm_pkg::sts_t                 sts,
  input  logic [wtm_pkg::MODE_W-1:0]    in_mode,
  input  logic [wtm_pkg::ADDR_W-1:0]    in_addr,
  input  logic [wtm_pkg::VALUE_W-1:0]   in_value,
  input  logic [wtm_pkg::METHOD_W-1:0]  in_match_method,
  input  logic                          in_width_type,
  input  logic [wtm_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_prev,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_at,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_next,
  output logic                          out_status,
  output logic [wtm_pkg::IDX_W-1:0]     out_new_index,
  output logic                          out_hit
);
  import wtm_pkg::*;

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // entry memory, contents undefined until written
  entry_t mem [ENTRIES];

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] rd_ptr_r;
  logic          tag_r;
  entry_t        rd_data_r;

  // captured item
  logic [MODE_W-1:0] mode_r;
  entry_t            item_r;
  logic [BYTE_W-1:0] byte_prev_r, byte_at_r, byte_next_r;
  logic              set_ok_r, rm_ok_r;
  logic              hit_r;

  // result register
  logic              status_r, status_nxt;
  logic [IDX_W-1:0]  new_index_r, new_index_nxt;
  logic              hit_out_r, hit_out_nxt;

  logic              set_ok, rm_ok;
  logic [CW-1:0]     rm_start;
  logic              match;
  logic [ADDR_W-1:0] next_addr;
  logic [VALUE_W-1:0] data;
  logic              addr_hit;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  entry_t            wr_data;

  assign set_ok   = (count_r < CW'(ENTRIES)) && (in_match_method != METH_BAD);
  assign rm_ok    = (CMPW'(in_entry_index) < CMPW'(count_r));
  assign rm_start = CW'(CMPW'(in_entry_index) + CMPW'(1));

  // walk pointer: lookup scans from 0, remove copies from index+1,
  // anything else starts at the end so the walk is empty
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      if (in_mode == MODE_LOOKUP) begin
        ptr_nxt = '0;
      end else if (in_mode == MODE_REMOVE && rm_ok) begin
        ptr_nxt = rm_start;
      end else begin
        ptr_nxt = count_r;
      end
    end else if (cmd.walk) begin
      ptr_nxt = ptr_r + CW'(1);
    end
  end

  assign sts.walk_done = (ptr_r >= count_r);
  assign sts.pend      = tag_r;

  // comparator on the entry read last cycle
  always_comb begin
    next_addr = rd_data_r.addr + ADDR_W'(1);
    addr_hit  = 1'b0;
    data      = {{(VALUE_W-BYTE_W){1'b0}}, byte_at_r};
    if (!rd_data_r.word) begin
      addr_hit = (item_r.addr == rd_data_r.addr);
    end else if (item_r.addr == rd_data_r.addr) begin
      addr_hit = 1'b1;
      data     = {byte_next_r, byte_at_r};
    end else if (item_r.addr == next_addr) begin
      addr_hit = 1'b1;
      data     = {byte_at_r, byte_prev_r};
    end
    match = addr_hit && method_fires(rd_data_r.method, data, rd_data_r.value);
  end

  // single write port: shift copy during remove, append on set commit
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = rd_ptr_r[IW-1:0] - IW'(1);
    wr_data = rd_data_r;
    if (tag_r && mode_r == MODE_REMOVE) begin
      wr_en = 1'b1;
    end else if (cmd.commit && mode_r == MODE_SET && set_ok_r) begin
      wr_en   = 1'b1;
      wr_idx  = count_r[IW-1:0];
      wr_data = item_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.commit) begin
      if (mode_r == MODE_SET && set_ok_r) begin
        count_nxt = count_r + CW'(1);
      end else if (mode_r == MODE_REMOVE && rm_ok_r) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd.walk) begin
      rd_data_r <= mem[ptr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      tag_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      tag_r   <= cmd.walk;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= ptr_r;
    if (cmd.load) begin
      mode_r        <= in_mode;
      item_r.addr   <= in_addr;
      item_r.value  <= in_value;
      item_r.method <= in_match_method;
      item_r.word   <= in_width_type;
      byte_prev_r   <= in_byte_prev;
      byte_at_r     <= in_byte_at;
      byte_next_r   <= in_byte_next;
      set_ok_r      <= set_ok;
      rm_ok_r       <= rm_ok;
      hit_r         <= 1'b0;
    end else if (tag_r && mode_r == MODE_LOOKUP && match) begin
      hit_r <= 1'b1;
    end
  end

  // result register
  always_comb begin
    status_nxt    = status_r;
    new_index_nxt = new_index_r;
    hit_out_nxt   = hit_out_r;
    if (cmd.commit) begin
      status_nxt    = 1'b1;
      new_index_nxt = '0;
      hit_out_nxt   = 1'b0;
      case (mode_r)
        MODE_SET: begin
          status_nxt = !set_ok_r;
          if (set_ok_r) begin
            new_index_nxt = IDX_W'(count_r);
          end
        end
        MODE_REMOVE: status_nxt = !rm_ok_r;
        MODE_LOOKUP: begin
          status_nxt  = 1'b0;
          hit_out_nxt = hit_r;
        end
        default: status_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    new_index_r <= new_index_nxt;
    hit_out_r   <= hit_out_nxt;
  end

  assign out_status    = status_r;
  assign out_new_index = new_index_r;
  assign out_hit       = hit_out_r;

endmodule

### hdl/watchpoint_table_matcher_core.sv
`timescale 1ns / 1ps
// walk: lookup reads every entry, remove shifts down the entries after the index,
// set, error and other words walk no entries; a result waits in finish while
// the previous result is still held for out_ready
// throughput: one word at a time through one comparator; the sequencer is back
// in idle as the result loads, so the next word can be taken while that result waits
// reset: sync active-low rst_n empties the table and idles the sequencer, no memory clear
// ----------------------------------------------------------------------------
// watchpoint_table_matcher_core
// debug watchpoint table with set, remove and lookup-by-access operations
// ----------------------------------------------------------------------------
module watchpoint_table_matcher_core #(
  parameter int ENTRIES = wtm_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wtm_pkg::MODE_W-1:0]    in_mode,
  input  logic [wtm_pkg::ADDR_W-1:0]    in_addr,
  input  logic [wtm_pkg::VALUE_W-1:0]   in_value,
  input  logic [wtm_pkg::METHOD_W-1:0]  in_match_method,
  input  logic                          in_width_type,
  input  logic [wtm_pkg::IDX_W-1:0]     in_entry_index,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_prev,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_at,
  input  logic [wtm_pkg::BYTE_W-1:0]    in_byte_next,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_status,
  output logic [wtm_pkg::IDX_W-1:0]     out_new_index,
  output logic                          out_hit
);
  import wtm_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle -> walk the table -> finish into the result register;
  // the result register lets a new word be accepted while the previous
  // result is still waiting on out_ready
  wtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: entry memory with registered read, walk pointer, one
  // address/data comparator for lookup, and the shift-down copy for remove
  wtm_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_mode),
    .in_addr         (in_addr),
    .in_value        (in_value),
    .in_match_method (in_match_method),
    .in_width_type   (in_width_type),
    .in_entry_index  (in_entry_index),
    .in_byte_prev    (in_byte_prev),
    .in_byte_at      (in_byte_at),
    .in_byte_next    (in_byte_next),
    .out_status      (out_status),
    .out_new_index   (out_new_index),
    .out_hit         (out_hit)
  );

endmodule
